// ----- rtl/skc_pkg.sv -----
package skc_pkg;

    localparam logic [1:0] FUNC_SCAN   = 2'd0;
    localparam logic [1:0] FUNC_INJECT = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    localparam logic [1:0] OP_NOP  = 2'd0;
    localparam logic [1:0] OP_PUSH = 2'd1;
    localparam logic [1:0] OP_POP  = 2'd2;

    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
    localparam logic [7:0] SC_BREAK_BIT    = 8'h80;
    localparam logic [7:0] CASE_OFFSET     = 8'd32;
    localparam int         MAP_SIZE        = 58;

    localparam logic [7:0] PLAIN_MAP [MAP_SIZE] = '{
        8'd0, 8'd27, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", 8'd8,
        8'd9, "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", 8'd10,
        8'd0, "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", 8'd39, 8'h60,
        8'd0, 8'd92, "z", "x", "c", "v", "b", "n", "m", ",", ".", "/", 8'd0,
        "*", 8'd0, " "
    };

    localparam logic [7:0] SHIFT_MAP [MAP_SIZE] = '{
        8'd0, 8'd27, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+", 8'd8,
        8'd9, "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}", 8'd10,
        8'd0, "A", "S", "D", "F", "G", "H", "J", "K", "L", ":", 8'd34, "~",
        8'd0, "|", "Z", "X", "C", "V", "B", "N", "M", "<", ">", "?", 8'd0,
        "*", 8'd0, " "
    };

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
    } t_op;

    function automatic logic [7:0] map_lookup(input logic [7:0] sc, input logic shift,
                                              input logic caps);
        logic [7:0] ch;
        ch = 8'd0;
        if (sc < 8'(MAP_SIZE)) begin
            ch = shift ? SHIFT_MAP[sc[5:0]] : PLAIN_MAP[sc[5:0]];
        end
        if (caps) begin
            if (ch >= "a" && ch <= "z") begin
                ch = ch - CASE_OFFSET;
            end else if (ch >= "A" && ch <= "Z" && shift) begin
                ch = ch + CASE_OFFSET;
            end
        end
        return ch;
    endfunction

endpackage

// ----- rtl/skc_front.sv -----
module skc_front import skc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_func,
    input  logic [7:0] i_data_byte,
    output logic       o_op_valid,
    output t_op        o_op,
    input  logic       i_op_ready
);

    logic r_disable, n_disable;
    logic r_shift, n_shift;
    logic r_caps, n_caps;
    logic w_take;
    logic [7:0] w_ch;

    assign o_in_ready = i_op_ready;
    assign o_op_valid = i_in_valid;
    assign w_take     = i_in_valid && i_op_ready;
    assign w_ch       = map_lookup(i_data_byte, r_shift, r_caps);

    always_comb begin
        n_disable = i_cfg_we ? i_cfg_data : r_disable;
        n_shift   = r_shift;
        n_caps    = r_caps;
        o_op.kind = OP_NOP;
        o_op.ch   = i_data_byte;
        unique case (i_func)
            FUNC_SCAN: begin
                priority if (r_disable) begin
                    o_op.kind = OP_NOP;
                end else if (i_data_byte == SC_LSHIFT_MAKE || i_data_byte == SC_RSHIFT_MAKE) begin
                    n_shift = w_take ? 1'b1 : r_shift;
                end else if (i_data_byte == SC_LSHIFT_BREAK ||
                             i_data_byte == SC_RSHIFT_BREAK) begin
                    n_shift = w_take ? 1'b0 : r_shift;
                end else if (i_data_byte == SC_CAPS_MAKE) begin
                    n_caps = r_caps ^ w_take;
                end else if ((i_data_byte & SC_BREAK_BIT) != 8'd0) begin
                    o_op.kind = OP_NOP;
                end else begin
                    o_op.ch   = w_ch;
                    o_op.kind = (w_ch != 8'd0) ? OP_PUSH : OP_NOP;
                end
            end
            FUNC_INJECT: o_op.kind = (i_data_byte != 8'd0) ? OP_PUSH : OP_NOP;
            FUNC_READ:   o_op.kind = OP_POP;
            default:     o_op.kind = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disable <= 1'b0;
            r_shift   <= 1'b0;
            r_caps    <= 1'b0;
        end else begin
            r_disable <= n_disable;
            r_shift   <= n_shift;
            r_caps    <= n_caps;
        end
    end

endmodule

// ----- rtl/skc_queue.sv -----
module skc_queue import skc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_op  i_push_op,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_op  o_pop_op
);

    t_op        r_ent [2];
    logic       r_head, n_head;
    logic [1:0] r_count, n_count;
    logic       w_push, w_pop, w_tail;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_op     = r_ent[r_head];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign w_tail       = r_head ^ r_count[0];

    always_comb begin
        n_head  = r_head ^ w_pop;
        n_count = r_count + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ent[w_tail] <= i_push_op;
        end
    end

endmodule

// ----- rtl/skc_back.sv -----
module skc_back import skc_pkg::*; #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_op_valid,
    output logic        o_op_ready,
    input  t_op         i_op,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_char,
    output logic        o_char_valid,
    output logic        o_fifo_nonempty,
    output logic [31:0] o_drop_count
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_POP  = 1'b1;

    logic [7:0]       r_mem [FIFO_DEPTH];
    logic [7:0]       r_rd_data;
    logic             r_state, n_state;
    logic [PTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [PTR_W-1:0] w_wr_inc, w_rd_inc;
    logic [31:0]      r_drop, n_drop;
    logic             r_pop_has, n_pop_has;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_char, n_char;
    logic             r_cvalid, n_cvalid;
    logic             r_has, n_has;
    logic             w_take, w_full, w_empty, w_write;

    assign w_wr_inc   = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
    assign w_rd_inc   = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
    assign w_full     = (w_wr_inc == r_rd);
    assign w_empty    = (r_wr == r_rd);
    assign o_op_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_take     = o_op_ready && i_op_valid;
    assign w_write    = w_take && (i_op.kind == OP_PUSH) && !w_full;

    assign o_out_valid     = r_out_valid;
    assign o_read_char     = r_char;
    assign o_char_valid    = r_cvalid;
    assign o_fifo_nonempty = r_has;
    assign o_drop_count    = r_drop;

    always_comb begin
        n_state     = r_state;
        n_wr        = r_wr;
        n_rd        = r_rd;
        n_drop      = r_drop;
        n_pop_has   = r_pop_has;
        n_out_valid = r_out_valid && !i_out_ready;
        n_char      = r_char;
        n_cvalid    = r_cvalid;
        n_has       = r_has;
        if (r_state == ST_POP) begin
            n_state     = ST_IDLE;
            n_out_valid = 1'b1;
            n_char      = r_rd_data;
            n_cvalid    = 1'b1;
            n_has       = r_pop_has;
        end else if (w_take) begin
            n_out_valid = 1'b1;
            n_char      = 8'd0;
            n_cvalid    = 1'b0;
            n_has       = !w_empty;
            unique case (i_op.kind)
                OP_PUSH: begin
                    if (w_full) begin
                        n_drop = r_drop + 32'd1;
                    end else begin
                        n_wr  = w_wr_inc;
                        n_has = 1'b1;
                    end
                end
                OP_POP: begin
                    if (!w_empty) begin
                        n_rd        = w_rd_inc;
                        n_pop_has   = (r_wr != w_rd_inc);
                        n_state     = ST_POP;
                        n_out_valid = 1'b0;
                    end
                end
                default: n_has = !w_empty;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wr        <= '0;
            r_rd        <= '0;
            r_drop      <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr        <= n_wr;
            r_rd        <= n_rd;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pop_has <= n_pop_has;
        r_char    <= n_char;
        r_cvalid  <= n_cvalid;
        r_has     <= n_has;
    end

    // character store
    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_mem[r_wr] <= i_op.ch;
        end
        r_rd_data <= r_mem[r_rd];
    end

endmodule

// ----- rtl/scancode_to_ascii_key_fifo.sv -----
// channel  | handshake                   | payload
// ---------+-----------------------------+----------------------------------------------
// request  | i_in_valid / o_in_ready     | i_func, i_data_byte
// result   | o_out_valid / i_out_ready   | o_read_char, o_char_valid, o_fifo_nonempty,
//          |                             | o_drop_count
// config   | i_cfg_we                    | i_cfg_data (scan disable)
//
// the front end classifies one request per cycle, while the queue has room, into a two-entry op queue
// scan, inject, idle and empty-read requests are answered straight from the idle state of the back end;
// a read that pops goes through the pop state for the registered read port of the character store
// reset clears pointers, shift, caps, drop count and the disable bit; no clearing pass
// a stalled result blocks the back end only; the queue keeps taking requests until full
module scancode_to_ascii_key_fifo import skc_pkg::*; #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_char,
    output logic        o_char_valid,
    output logic        o_fifo_nonempty,
    output logic [31:0] o_drop_count
);

    logic w_fq_valid, w_fq_ready, w_qb_valid, w_qb_ready;
    t_op  w_fq_op, w_qb_op;

    skc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_data_byte (i_data_byte),
        .o_op_valid  (w_fq_valid),
        .o_op        (w_fq_op),
        .i_op_ready  (w_fq_ready)
    );

    skc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fq_valid),
        .o_push_ready (w_fq_ready),
        .i_push_op    (w_fq_op),
        .o_pop_valid  (w_qb_valid),
        .i_pop_ready  (w_qb_ready),
        .o_pop_op     (w_qb_op)
    );

    skc_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op_valid      (w_qb_valid),
        .o_op_ready      (w_qb_ready),
        .i_op            (w_qb_op),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_read_char     (o_read_char),
        .o_char_valid    (o_char_valid),
        .o_fifo_nonempty (o_fifo_nonempty),
        .o_drop_count    (o_drop_count)
    );

endmodule

// ----- sim/tb.sv -----
module tb;
    import skc_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         KEY_CODES   = 58;
    localparam int         HOLD_CYCLES = 60;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         PHASES      = 8;
    localparam int         PHASE_ITEMS = 95;

    localparam logic [7:0] KEYS_PLAIN [KEY_CODES] = '{
        8'd0, 8'd27, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", 8'd8,
        8'd9, "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", 8'd10,
        8'd0, "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", 8'd39, 8'h60,
        8'd0, 8'd92, "z", "x", "c", "v", "b", "n", "m", ",", ".", "/", 8'd0,
        "*", 8'd0, " "
    };

    localparam logic [7:0] KEYS_SHIFT [KEY_CODES] = '{
        8'd0, 8'd27, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+", 8'd8,
        8'd9, "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}", 8'd10,
        8'd0, "A", "S", "D", "F", "G", "H", "J", "K", "L", ":", 8'd34, "~",
        8'd0, "|", "Z", "X", "C", "V", "B", "N", "M", "<", ">", "?", 8'd0,
        "*", 8'd0, " "
    };

    localparam int READ_MIX    [PHASES] = '{30, 10, 10, 5, 5, 10, 60, 70};
    localparam bit SCAN_OFF_AT [PHASES] = '{0, 0, 1, 0, 0, 0, 1, 0};

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data;
    } t_key_request;

    typedef struct packed {
        logic [7:0]  ch;
        logic        valid;
        logic        has;
        logic [31:0] drops;
    } t_key_result;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic        i_cfg_data      = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic [1:0]  i_func          = 2'd0;
    logic [7:0]  i_data_byte     = 8'd0;
    logic        i_out_ready     = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_read_char;
    logic        o_char_valid;
    logic        o_fifo_nonempty;
    logic [31:0] o_drop_count;

    // predictor state
    logic [7:0]  key_store [256];
    logic [7:0]  wr_ptr      = 8'd0;
    logic [7:0]  rd_ptr      = 8'd0;
    logic        shift_on    = 1'b0;
    logic        caps_active = 1'b0;
    logic [31:0] drops       = 32'd0;
    logic        scan_off    = 1'b0;

    t_key_request pending_requests [$];
    t_key_result  expected_keys [$];
    int           items_queued   = 0;
    int           results_seen   = 0;
    int           mismatches     = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    int           cycles         = 0;
    int           hold_left      = 0;
    logic         hold_req       = 1'b0;

    scancode_to_ascii_key_fifo i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_read_char     (o_read_char),
        .o_char_valid    (o_char_valid),
        .o_fifo_nonempty (o_fifo_nonempty),
        .o_drop_count    (o_drop_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void push_char(input logic [7:0] ch);
        if (8'(wr_ptr + 8'd1) != rd_ptr) begin
            key_store[wr_ptr] = ch;
            wr_ptr = wr_ptr + 8'd1;
        end else begin
            drops = drops + 32'd1;
        end
    endfunction

    function automatic t_key_result apply_request(input logic [1:0] f, input logic [7:0] d);
        t_key_result r;
        logic [7:0]  ch;
        r  = '0;
        ch = 8'd0;
        case (f)
            FUNC_SCAN: begin
                if (!scan_off) begin
                    if (d == SC_LSHIFT_MAKE || d == SC_RSHIFT_MAKE) begin
                        shift_on = 1'b1;
                    end else if (d == SC_LSHIFT_BREAK || d == SC_RSHIFT_BREAK) begin
                        shift_on = 1'b0;
                    end else if (d == SC_CAPS_MAKE) begin
                        caps_active = !caps_active;
                    end else if ((d & SC_BREAK_BIT) == 8'd0 && d < KEY_CODES) begin
                        ch = shift_on ? KEYS_SHIFT[d[5:0]] : KEYS_PLAIN[d[5:0]];
                        if (caps_active) begin
                            if (ch >= "a" && ch <= "z") begin
                                ch = ch - CASE_OFFSET;
                            end else if (ch >= "A" && ch <= "Z" && shift_on) begin
                                ch = ch + CASE_OFFSET;
                            end
                        end
                        if (ch != 8'd0) begin
                            push_char(ch);
                        end
                    end
                end
            end
            FUNC_INJECT: begin
                if (d != 8'd0) begin
                    push_char(d);
                end
            end
            FUNC_READ: begin
                if (wr_ptr != rd_ptr) begin
                    r.ch    = key_store[rd_ptr];
                    r.valid = 1'b1;
                    rd_ptr  = rd_ptr + 8'd1;
                end
            end
            default: begin
            end
        endcase
        r.has   = (wr_ptr != rd_ptr);
        r.drops = drops;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s at result %0d: got %0h, expected %0h",
                 field, results_seen, got, want);
        mismatches++;
    endtask

    task automatic queue_item(input logic [1:0] f, input logic [7:0] d);
        t_key_request req;
        req.func = f;
        req.data = d;
        pending_requests.push_back(req);
        items_queued++;
    endtask

    task automatic add_random_request(input int read_pct);
        int         r;
        int         k;
        logic [7:0] code;
        r = $urandom_range(99);
        if (r < read_pct) begin
            queue_item(FUNC_READ, 8'($urandom));
        end else if (r < read_pct + 4) begin
            queue_item(FUNC_UNUSED, 8'($urandom));
        end else if (r < read_pct + 8) begin
            queue_item(FUNC_SCAN, 8'($urandom));
        end else if (r < read_pct + 18) begin
            queue_item(FUNC_INJECT,
                       ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(255, 1)));
        end else begin
            // keyboard typing with shift and caps sequences
            k = $urandom_range(99);
            if (k < 8) begin
                code = $urandom_range(1) ? SC_LSHIFT_MAKE : SC_RSHIFT_MAKE;
            end else if (k < 16) begin
                code = $urandom_range(1) ? SC_LSHIFT_BREAK : SC_RSHIFT_BREAK;
            end else if (k < 20) begin
                code = SC_CAPS_MAKE;
            end else if (k < 28) begin
                code = 8'($urandom_range(KEY_CODES - 1)) | SC_BREAK_BIT;
            end else begin
                code = 8'($urandom_range(KEY_CODES - 1));
            end
            queue_item(FUNC_SCAN, code);
        end
    endtask

    task automatic wait_drained();
        while (results_seen != items_queued) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_scan_disable(input logic v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        scan_off    = v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic pulse_hold();
        @(posedge i_clk);
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
    endtask

    // request driver
    always @(posedge i_clk) begin
        t_key_request req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_keys.push_back(apply_request(i_func, i_data_byte));
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req = pending_requests.pop_front();
                    i_in_valid  <= 1'b1;
                    i_func      <= req.func;
                    i_data_byte <= req.data;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_req) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_key_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_keys.size() == 0) begin
                    report_mismatch("unexpected result", o_drop_count, 32'd0);
                end else begin
                    want = expected_keys.pop_front();
                    if (o_read_char !== want.ch) begin
                        report_mismatch("read_char", 32'(o_read_char), 32'(want.ch));
                    end
                    if (o_char_valid !== want.valid) begin
                        report_mismatch("char_valid", 32'(o_char_valid), 32'(want.valid));
                    end
                    if (o_fifo_nonempty !== want.has) begin
                        report_mismatch("fifo_nonempty", 32'(o_fifo_nonempty),
                                        32'(want.has));
                    end
                    if (o_drop_count !== want.drops) begin
                        report_mismatch("drop_count", o_drop_count, want.drops);
                    end
                    results_seen++;
                end
            end
            i_out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_scan_disable(1'b0);

        // empty read, unused func, zero inject, unmapped codes
        queue_item(FUNC_READ, 8'hFF);
        queue_item(FUNC_UNUSED, 8'h00);
        queue_item(FUNC_UNUSED, 8'hFF);
        queue_item(FUNC_INJECT, 8'h00);
        queue_item(FUNC_INJECT, 8'hFF);
        queue_item(FUNC_SCAN, 8'h00);
        queue_item(FUNC_SCAN, 8'h3B);
        queue_item(FUNC_SCAN, 8'h7F);
        queue_item(FUNC_SCAN, 8'h10);
        // shift, caps and their interaction
        queue_item(FUNC_SCAN, SC_LSHIFT_MAKE);
        queue_item(FUNC_SCAN, 8'h10);
        queue_item(FUNC_SCAN, 8'h02);
        queue_item(FUNC_SCAN, SC_CAPS_MAKE);
        queue_item(FUNC_SCAN, 8'h10);
        queue_item(FUNC_SCAN, SC_LSHIFT_BREAK);
        queue_item(FUNC_SCAN, 8'h10);
        queue_item(FUNC_SCAN, 8'h02);
        queue_item(FUNC_SCAN, SC_RSHIFT_MAKE);
        queue_item(FUNC_SCAN, SC_RSHIFT_BREAK);
        queue_item(FUNC_SCAN, SC_CAPS_MAKE);
        queue_item(FUNC_SCAN, 8'h80);
        queue_item(FUNC_SCAN, 8'hFF);
        queue_item(FUNC_SCAN, 8'h39);
        repeat (4) queue_item(FUNC_READ, 8'h00);
        wait_drained();

        // scan codes ignored while disabled, inject and read still work
        write_scan_disable(1'b1);
        queue_item(FUNC_SCAN, SC_LSHIFT_MAKE);
        queue_item(FUNC_SCAN, SC_CAPS_MAKE);
        queue_item(FUNC_SCAN, 8'h10);
        queue_item(FUNC_INJECT, 8'h41);
        queue_item(FUNC_READ, 8'h00);
        queue_item(FUNC_READ, 8'h00);
        wait_drained();
        write_scan_disable(1'b0);
        queue_item(FUNC_SCAN, 8'h10);
        queue_item(FUNC_READ, 8'h00);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            write_scan_disable(SCAN_OFF_AT[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                add_random_request(READ_MIX[p]);
            end
            if (p % 4 == 0) begin
                pulse_hold();
            end
            wait_drained();
        end

        if (expected_keys.size() != 0) begin
            report_mismatch("results missing", 32'(expected_keys.size()), 32'd0);
        end
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/skc_pkg.sv
rtl/skc_front.sv
rtl/skc_queue.sv
rtl/skc_back.sv
rtl/scancode_to_ascii_key_fifo.sv
sim/tb.sv
